FILE: rtl/gtu_pkg.sv
`default_nettype none

package gtu_pkg;

  localparam int KIND_W   = 2;
  localparam int VERTEX_W = 4;
  localparam int COUNT_W  = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RUN    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRAVERSAL_MODE = 1'd1;

  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 5'd16;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [VERTEX_W-1:0] vertex;
    logic [VERTEX_W-1:0] neighbour;
  } in_item_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] visited_vertex;
    logic                last;
    logic                error;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/gtu_ram.sv
`default_nettype none

module gtu_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/gtu_engine.sv
`default_nettype none

module gtu_engine #(
  parameter int MAX_VERTICES = 16,
  parameter int MAX_DEGREE = 8,
  localparam int CW = $clog2(MAX_VERTICES + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire gtu_pkg::in_item_t item,
  input  wire logic [CW-1:0]     count,
  input  wire logic              mode,
  output logic                   result_valid,
  output gtu_pkg::out_item_t     result
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int PW = VW + 1;
  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam int AW = $clog2(MAX_VERTICES * MAX_DEGREE);
  localparam int EW = (CW > gtu_pkg::VERTEX_W) ? CW : gtu_pkg::VERTEX_W;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_POP     = 3'd1;
  localparam logic [2:0] S_CUR     = 3'd2;
  localparam logic [2:0] S_ADJ_RD  = 3'd3;
  localparam logic [2:0] S_ADJ_CHK = 3'd4;

  logic [2:0]              state;
  logic [PW-1:0]           head;
  logic [PW-1:0]           tail;
  logic [VW-1:0]           cur;
  logic [DW-1:0]           deg;
  logic [DW-1:0]           j;
  logic                    pend_valid;
  logic [VW-1:0]           pend_vertex;
  logic [MAX_VERTICES-1:0] visited;
  logic [DW-1:0]           degree [MAX_VERTICES];

  logic [VW-1:0]                 vidx;
  logic [VW-1:0]                 deg_addr;
  logic [DW-1:0]                 deg_rd;
  logic                          owner_ok;
  logic                          append_ok;
  logic                          start_ok;
  logic                          accept;
  logic                          emit;
  logic                          adj_we;
  logic [AW-1:0]                 adj_waddr;
  logic [AW-1:0]                 adj_raddr;
  logic [gtu_pkg::VERTEX_W-1:0]  adj_rdata;
  logic [VW-1:0]                 nidx;
  logic                          nb_ok;
  logic                          push_ok;
  logic                          fr_we;
  logic [VW-1:0]                 fr_waddr;
  logic [VW-1:0]                 fr_wdata;
  logic [VW-1:0]                 fr_raddr;
  logic [VW-1:0]                 fr_rdata;

  assign busy      = (state != S_IDLE);
  assign accept    = start && (state == S_IDLE);
  assign vidx      = VW'(item.vertex);
  assign deg_addr  = (state == S_CUR) ? fr_rdata : vidx;
  assign deg_rd    = degree[deg_addr];
  assign owner_ok  = (32'(item.vertex) < 32'(MAX_VERTICES));
  assign append_ok = owner_ok && (deg_rd < DW'(MAX_DEGREE));
  assign start_ok  = (EW'(item.vertex) < EW'(count));

  assign emit = (accept && (item.kind == gtu_pkg::KIND_APPEND) && !append_ok) ||
                (accept && (item.kind == gtu_pkg::KIND_RUN) && !start_ok) ||
                ((state == S_POP) && (head == tail)) ||
                ((state == S_CUR) && pend_valid);

  assign adj_we    = accept && (item.kind == gtu_pkg::KIND_APPEND) && append_ok;
  assign adj_waddr = AW'(vidx) * AW'(MAX_DEGREE) + AW'(deg_rd);
  assign adj_raddr = AW'(cur) * AW'(MAX_DEGREE) + AW'(j);

  assign nidx    = VW'(adj_rdata);
  assign nb_ok   = (EW'(adj_rdata) < EW'(count));
  assign push_ok = nb_ok && !visited[nidx] && (tail < PW'(MAX_VERTICES));

  assign fr_we    = (accept && (item.kind == gtu_pkg::KIND_RUN) && start_ok) ||
                    ((state == S_ADJ_CHK) && push_ok);
  assign fr_waddr = (state == S_IDLE) ? '0 : tail[VW-1:0];
  assign fr_wdata = (state == S_IDLE) ? vidx : nidx;
  assign fr_raddr = mode ? VW'(tail - PW'(1)) : head[VW-1:0];

  gtu_ram #(
    .WIDTH (gtu_pkg::VERTEX_W),
    .DEPTH (MAX_VERTICES * MAX_DEGREE)
  ) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (item.neighbour),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  gtu_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_VERTICES)
  ) u_frontier_ram (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (fr_wdata),
    .raddr (fr_raddr),
    .rdata (fr_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head         <= '0;
      tail         <= '0;
      visited      <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
        degree[i] <= '0;
      end
    end else begin
      result_valid <= emit;
      case (state)
        S_IDLE: begin
          if (start) begin
            case (item.kind)
              gtu_pkg::KIND_CLEAR: begin
                for (int i = 0; i < MAX_VERTICES; i++) begin
                  degree[i] <= '0;
                end
              end
              gtu_pkg::KIND_APPEND: begin
                if (append_ok) begin
                  degree[vidx] <= deg_rd + DW'(1);
                end else begin
                  result <= '{visited_vertex: '0, last: 1'b0, error: 1'b1};
                end
              end
              gtu_pkg::KIND_RUN: begin
                head       <= '0;
                pend_valid <= 1'b0;
                if (start_ok) begin
                  visited <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << vidx;
                  tail    <= PW'(1);
                  state   <= S_POP;
                end else begin
                  visited <= '0;
                  tail    <= '0;
                  result  <= '{visited_vertex: '0, last: 1'b0, error: 1'b1};
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_POP: begin
          if (head == tail) begin
            result       <= '{visited_vertex: gtu_pkg::VERTEX_W'(pend_vertex),
                              last: 1'b1, error: 1'b0};
            head         <= '0;
            tail         <= '0;
            state        <= S_IDLE;
          end else begin
            if (mode) begin
              tail <= tail - PW'(1);
            end else begin
              head <= head + PW'(1);
            end
            state <= S_CUR;
          end
        end
        S_CUR: begin
          if (pend_valid) begin
            result       <= '{visited_vertex: gtu_pkg::VERTEX_W'(pend_vertex),
                              last: 1'b0, error: 1'b0};
          end
          cur         <= fr_rdata;
          pend_vertex <= fr_rdata;
          pend_valid  <= 1'b1;
          deg         <= deg_rd;
          j           <= '0;
          state       <= S_ADJ_RD;
        end
        S_ADJ_RD: begin
          if (j < deg) begin
            state <= S_ADJ_CHK;
          end else begin
            state <= S_POP;
          end
        end
        S_ADJ_CHK: begin
          if (push_ok) begin
            visited[nidx] <= 1'b1;
            tail          <= tail + PW'(1);
          end
          j     <= j + DW'(1);
          state <= S_ADJ_RD;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_tail_bound: assert property (@(posedge clk) disable iff (rst)
    tail <= PW'(MAX_VERTICES))
    else $error("Frontier tail passed the frontier depth.");

  a_head_le_tail: assert property (@(posedge clk) disable iff (rst)
    !mode |-> head <= tail)
    else $error("Queue head passed the queue tail.");

  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.last || result.error)) |-> !busy)
    else $error("A final or error transfer appeared while the engine was busy.");

  a_list_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADJ_CHK) |-> (j < deg))
    else $error("Neighbor index ran past the list length.");

endmodule

`default_nettype wire

FILE: rtl/graph_traversal_bfs_dfs_unit.sv
// Clear and append items leave busy low, so one can be accepted every cycle.
// An error result appears in the cycle after the item that causes it.
// A run walks the adjacency lists one entry at a time through the single adjacency memory read port.
// Results come out as single-cycle strobes and the receiver cannot stall them.
// Reset empties every list, clears the visited map and sets vertex count 16, breadth first.
`default_nettype none

module graph_traversal_bfs_dfs_unit #(
  parameter int MAX_VERTICES = 16,
  parameter int MAX_DEGREE = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire gtu_pkg::in_item_t                  item,
  input  wire logic                               cfg_we,
  input  wire logic [gtu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [gtu_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                    result_valid,
  output gtu_pkg::out_item_t                      result
);

  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int XW = (CW > gtu_pkg::COUNT_W) ? CW : gtu_pkg::COUNT_W;

  logic [gtu_pkg::COUNT_W-1:0] vertex_count;
  logic                        traversal_mode;
  logic [XW-1:0]               count_ext;
  logic [CW-1:0]               eff_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count   <= gtu_pkg::VERTEX_COUNT_RESET;
      traversal_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        gtu_pkg::REG_VERTEX_COUNT: begin
          vertex_count <= cfg_data;
        end
        gtu_pkg::REG_TRAVERSAL_MODE: begin
          traversal_mode <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  assign count_ext = XW'(vertex_count);
  assign eff_count = (count_ext > XW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(count_ext);

  gtu_engine #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_DEGREE   (MAX_DEGREE)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .count        (eff_count),
    .mode         (traversal_mode),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire
